// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, codes and types for the entry memory and its control logic.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Queue capacity and derived widths.
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Fixed field widths of the item formats.
   localparam int REQ_W    = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int FILL_W   = 5;
   localparam int REQ_TDATA_W = ((REQ_W + 2 * DATA_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((STATUS_W + 2 * DATA_W + FILL_W + 7) / 8) * 8;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT  = 2'd0,
      REQ_DELETE  = 2'd1,
      REQ_CLEAR   = 2'd2,
      REQ_READOUT = 2'd3
   } req_code_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_DELETED  = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_CLEARED  = 3'd4,
      ST_ENTRY    = 3'd5,
      ST_EMPTY    = 3'd6
   } status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_INS_HEAD,
      S_DELETE,
      S_READOUT,
      S_FINISH
   } state_type;

   // One queue entry.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   // Control bundle from the sequencer to the entry memory.
   typedef struct packed {
      logic      rd_en;
      idx_type   rd_addr;
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
   } ram_ctrl_type;

endpackage

// ===== design/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of (value, priority) entries kept in served order in one
// memory. Insert, delete by value, clear and in-order read out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   req_*    in         request item: req_type, item_value, item_priority
//   rsp_*    out        result item: status, out_value, out_priority,
//                       fill_count, with last on rsp_tlast
//
// An item walks the single-port-read entry memory, one entry per cycle: insert
// walks down from the tail, shifting each entry of higher priority up (no walk
// into an empty or a full queue); delete scans every held entry; clear needs no
// walk; read out halts while results stall. One item is worked on at a time.
// Reset clears the fill count and the sequencer; the memory needs no clearing.
// A stalled result channel stops read out and holds the final result.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_type [1:0], item_value [33:2], item_priority [65:34], zero pad
   input  logic [spq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [2:0], out_value [34:3], out_priority [66:35], fill_count [71:67]
   output logic [spq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast
);
   import spq_pkg::*;

   // Request field unpacking.
   req_code_type             req_code;
   logic signed [DATA_W-1:0] req_value;
   logic signed [DATA_W-1:0] req_priority;
   logic                     req_fire;

   assign req_code     = req_code_type'(req_tdata[REQ_W-1:0]);
   assign req_value    = req_tdata[REQ_W +: DATA_W];
   assign req_priority = req_tdata[REQ_W + DATA_W +: DATA_W];

   // Control and payload registers.
   state_type                state_ff, state_in;
   cnt_type                  count_ff, count_in;
   idx_type                  idx_ff, idx_in;
   idx_type                  last_idx_ff, last_idx_in;
   logic                     found_ff, found_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] prio_ff, prio_in;

   // Output register.
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic signed [DATA_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic [FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     slot_free;

   ram_ctrl_type ram_ctrl;
   entry_type    rd_entry;
   entry_type    new_entry;

   spq_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (rd_entry)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign new_entry  = '{value: value_ff, prio: prio_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_code)
                  REQ_INSERT: begin
                     if (count_ff == cnt_type'(DEPTH) || count_ff == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_INSERT;
                     end
                  end
                  REQ_DELETE:  state_in = (count_ff == '0) ? S_FINISH : S_DELETE;
                  REQ_CLEAR:   state_in = S_FINISH;
                  REQ_READOUT: state_in = (count_ff == '0) ? S_FINISH : S_READOUT;
                  default:     state_in = S_FINISH;
               endcase
            end
         end
         S_INSERT: begin
            if (rd_entry.prio > prio_ff) begin
               if (idx_ff == '0) begin
                  state_in = S_INS_HEAD;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_INS_HEAD: state_in = S_FINISH;
         S_DELETE: begin
            if (idx_ff == last_idx_ff) begin
               state_in = S_FINISH;
            end
         end
         S_READOUT: begin
            if (slot_free && idx_ff == last_idx_ff) begin
               state_in = S_IDLE;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory control and result loading.
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      last_idx_in   = last_idx_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      prio_in       = prio_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_last_in   = rsp_last_ff;
      ram_ctrl      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               value_in    = req_value;
               prio_in     = req_priority;
               found_in    = 1'b0;
               last_idx_in = idx_type'(count_ff - cnt_type'(1));
               unique case (req_code)
                  REQ_INSERT: begin
                     if (count_ff == cnt_type'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        // Empty queue: the new entry goes straight to the head.
                        ram_ctrl.wr_en   = 1'b1;
                        ram_ctrl.wr_addr = '0;
                        ram_ctrl.wr_data = '{value: req_value, prio: req_priority};
                        count_in         = cnt_type'(1);
                        status_in        = ST_INSERTED;
                     end else begin
                        // Walk down from the tail.
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = idx_type'(count_ff - cnt_type'(1));
                        idx_in           = idx_type'(count_ff - cnt_type'(1));
                     end
                  end
                  REQ_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = '0;
                        idx_in           = '0;
                     end
                  end
                  REQ_CLEAR: begin
                     count_in  = '0;
                     status_in = ST_CLEARED;
                  end
                  REQ_READOUT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ram_ctrl.rd_en   = 1'b1;
                        ram_ctrl.rd_addr = '0;
                        idx_in           = '0;
                     end
                  end
                  default: status_in = ST_EMPTY;
               endcase
            end
         end

         // Entries of higher priority number move up one place; the new
         // entry lands just above the first one that does not.
         S_INSERT: begin
            ram_ctrl.wr_en = 1'b1;
            if (rd_entry.prio > prio_ff) begin
               ram_ctrl.wr_addr = idx_ff + idx_type'(1);
               ram_ctrl.wr_data = rd_entry;
               if (idx_ff != '0) begin
                  ram_ctrl.rd_en   = 1'b1;
                  ram_ctrl.rd_addr = idx_ff - idx_type'(1);
                  idx_in           = idx_ff - idx_type'(1);
               end
            end else begin
               ram_ctrl.wr_addr = idx_ff + idx_type'(1);
               ram_ctrl.wr_data = new_entry;
               count_in         = count_ff + cnt_type'(1);
               status_in        = ST_INSERTED;
            end
         end

         S_INS_HEAD: begin
            ram_ctrl.wr_en   = 1'b1;
            ram_ctrl.wr_addr = '0;
            ram_ctrl.wr_data = new_entry;
            count_in         = count_ff + cnt_type'(1);
            status_in        = ST_INSERTED;
         end

         // Scan forward; after the first match every entry moves down one.
         S_DELETE: begin
            if (found_ff) begin
               ram_ctrl.wr_en   = 1'b1;
               ram_ctrl.wr_addr = idx_ff - idx_type'(1);
               ram_ctrl.wr_data = rd_entry;
            end else if (rd_entry.value == value_ff) begin
               found_in = 1'b1;
            end
            if (idx_ff == last_idx_ff) begin
               if (found_ff || rd_entry.value == value_ff) begin
                  count_in  = count_ff - cnt_type'(1);
                  status_in = ST_DELETED;
               end else begin
                  status_in = ST_NOTFOUND;
               end
            end else begin
               ram_ctrl.rd_en   = 1'b1;
               ram_ctrl.rd_addr = idx_ff + idx_type'(1);
               idx_in           = idx_ff + idx_type'(1);
            end
         end

         // One entry per cycle while the result slot is free.
         S_READOUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ENTRY;
               rsp_value_in  = rd_entry.value;
               rsp_prio_in   = rd_entry.prio;
               rsp_fill_in   = FILL_W'(count_ff);
               rsp_last_in   = (idx_ff == last_idx_ff);
               if (idx_ff != last_idx_ff) begin
                  ram_ctrl.rd_en   = 1'b1;
                  ram_ctrl.rd_addr = idx_ff + idx_type'(1);
                  idx_in           = idx_ff + idx_type'(1);
               end
            end
         end

         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = '0;
               rsp_prio_in   = '0;
               rsp_fill_in   = FILL_W'(count_ff);
               rsp_last_in   = 1'b1;
            end
         end

         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      last_idx_ff   <= last_idx_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      prio_ff       <= prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Result packing.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_fill_ff, rsp_prio_ff, rsp_value_ff,
                                     rsp_status_ff});

   // The fill count never goes beyond capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(DEPTH))
      else $error("fill count beyond capacity");

   // Writes stay within the held entries plus the one being added.
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_ctrl.wr_en |-> cnt_type'(ram_ctrl.wr_addr) <= count_ff)
      else $error("entry write beyond fill");

   // A walk never reads the entry it writes in the same cycle.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (ram_ctrl.wr_en && ram_ctrl.rd_en) |-> ram_ctrl.wr_addr != ram_ctrl.rd_addr)
      else $error("read and write to the same entry");

   // An entry result only comes from a nonempty queue.
   a_entry_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_ENTRY) |-> rsp_fill_ff != '0)
      else $error("entry result from empty queue");

   // After an accepted request no other is taken in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while busy");

endmodule

// ===== design/spq_ram.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue entry memory
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module spq_ram (
   input  logic                 clock,
   input  spq_pkg::ram_ctrl_type ctrl,
   output spq_pkg::entry_type   rd_data
);
   import spq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/sorted_priority_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches both streams of the queue. It keeps a shadow copy of the entries,
// works out the result items of every accepted request and compares each
// accepted result item, field by field, with the oldest one awaited.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // req_type [1:0], item_value [33:2], item_priority [65:34], zero pad
   input  logic [spq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [2:0], out_value [34:3], out_priority [66:35], fill_count [71:67]
   input  logic [spq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   output int                               mismatch_count,
   output int                               awaited_count,
   output int                               checked_count
);
   import spq_pkg::*;

   // One result item as the queue should produce it.
   typedef struct {
      status_type         status;
      logic [DATA_W-1:0]  value;
      logic [DATA_W-1:0]  prio;
      logic [FILL_W-1:0]  fill;
      logic               last;
   } queue_result_type;

   // Shadow copy of the entries in served order.
   logic signed [DATA_W-1:0] shadow_values [DEPTH];
   logic signed [DATA_W-1:0] shadow_prios  [DEPTH];
   int                       shadow_count = 0;

   queue_result_type awaited_results [$];
   int errors  = 0;
   int checked = 0;

   task automatic await_result(input status_type status, input logic [DATA_W-1:0] value,
                               input logic [DATA_W-1:0] prio, input logic last);
      queue_result_type r;
      r.status = status;
      r.value  = value;
      r.prio   = prio;
      r.fill   = FILL_W'(shadow_count);
      r.last   = last;
      awaited_results.push_back(r);
   endtask

   // Apply one request to the shadow queue and note the result items it causes.
   task automatic serve_request(input logic [REQ_TDATA_W-1:0] data);
      req_code_type             code;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      int                       pos;
      code  = req_code_type'(data[REQ_W-1:0]);
      value = data[REQ_W +: DATA_W];
      prio  = data[REQ_W + DATA_W +: DATA_W];
      case (code)
         REQ_INSERT: begin
            if (shadow_count >= DEPTH) begin
               await_result(ST_FULL, '0, '0, 1'b1);
            end else begin
               // Equal priorities go behind the ones already held.
               pos = 0;
               while (pos < shadow_count && shadow_prios[pos] <= prio) pos++;
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_values[i] = shadow_values[i-1];
                  shadow_prios[i]  = shadow_prios[i-1];
               end
               shadow_values[pos] = value;
               shadow_prios[pos]  = prio;
               shadow_count++;
               await_result(ST_INSERTED, '0, '0, 1'b1);
            end
         end
         REQ_DELETE: begin
            pos = 0;
            while (pos < shadow_count && shadow_values[pos] != value) pos++;
            if (pos >= shadow_count) begin
               await_result(ST_NOTFOUND, '0, '0, 1'b1);
            end else begin
               for (int i = pos; i + 1 < shadow_count; i++) begin
                  shadow_values[i] = shadow_values[i+1];
                  shadow_prios[i]  = shadow_prios[i+1];
               end
               shadow_count--;
               await_result(ST_DELETED, '0, '0, 1'b1);
            end
         end
         REQ_CLEAR: begin
            shadow_count = 0;
            await_result(ST_CLEARED, '0, '0, 1'b1);
         end
         default: begin
            if (shadow_count == 0) begin
               await_result(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < shadow_count; i++)
                  await_result(ST_ENTRY, shadow_values[i], shadow_prios[i],
                               (i + 1 == shadow_count));
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      queue_result_type want;
      if (awaited_results.size() == 0) begin
         $error("result item with status %0d arrived with none awaited",
                rsp_tdata[STATUS_W-1:0]);
         errors++;
      end else begin
         want = awaited_results.pop_front();
         compare_field("status", DATA_W'(want.status), DATA_W'(rsp_tdata[STATUS_W-1:0]));
         compare_field("out_value", want.value, rsp_tdata[STATUS_W +: DATA_W]);
         compare_field("out_priority", want.prio, rsp_tdata[STATUS_W + DATA_W +: DATA_W]);
         compare_field("fill_count", DATA_W'(want.fill),
                       DATA_W'(rsp_tdata[STATUS_W + 2*DATA_W +: FILL_W]));
         compare_field("last", DATA_W'(want.last), DATA_W'(rsp_tlast));
         checked++;
      end
   endtask

   // Requests are taken first so that a result of the same edge finds its entry.
   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         awaited_results.delete();
      end else begin
         if (req_tvalid && req_tready) serve_request(req_tdata);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      mismatch_count <= errors;
      awaited_count  <= awaited_results.size();
      checked_count  <= checked;
   end

endmodule

// ===== tb/sv/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives directed and random requests into the queue with random gaps on
// both streams and leaves the checking to the checker beside the block.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
   import spq_pkg::*;

   localparam int MAX_GAP      = 16;
   localparam int RANDOM_ITEMS = 285;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   int mismatch_count;
   int awaited_count;
   int checked_count;
   int gap_limit = MAX_GAP;
   int sent_by_kind [4] = '{0, 0, 0, 0};

   // Small set of values so that deletes often find a match.
   logic [DATA_W-1:0] value_pool [8] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7, 32'd42,
                                         32'h7FFF_FFFF, 32'h8000_0000, 32'd1000};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sorted_priority_queue_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .checked_count  (checked_count)
   );

   // Offer one request item after a random gap and hold it until it is taken.
   // Valid stays high across a zero gap so that it is never lowered and raised at once.
   task automatic send_request(input req_code_type code, input logic [DATA_W-1:0] value,
                               input logic [DATA_W-1:0] prio);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - REQ_W - 2 * DATA_W){1'b0}}, prio, value, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_by_kind[code]++;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 1)) return value_pool[$urandom_range(0, 7)];
      return $urandom();
   endfunction

   // Result side: a random stall before each result item.
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = $urandom_range(0, gap_limit);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Watchdog: the run ends if no item moves on either stream for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $error("no item moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int                op;
      logic [DATA_W-1:0] prio;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty queue: read out and delete both have nothing to work on.
      send_request(REQ_READOUT, '0, '0);
      send_request(REQ_DELETE, 32'd5, '0);
      // Extremes of value and priority, a tie in priority and a repeated value.
      send_request(REQ_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 32'd7, 32'd0);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'd0);
      send_request(REQ_INSERT, 32'd7, 32'hFFFF_FFFF);
      send_request(REQ_READOUT, '0, '0);
      // Only the first of the two sevens in served order goes.
      send_request(REQ_DELETE, 32'd7, '0);
      send_request(REQ_DELETE, 32'd12345, '0);
      // Fill to the bound, then one insert too many.
      for (int i = 0; i < DEPTH - 4; i++)
         send_request(REQ_INSERT, $urandom(), $urandom_range(0, 4) - 2);
      send_request(REQ_INSERT, 32'd99, 32'd0);
      send_request(REQ_READOUT, '0, '0);
      send_request(REQ_CLEAR, '0, '0);
      send_request(REQ_READOUT, '0, '0);

      // Random part: inserts outweigh deletes so that the queue fills up often.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) gap_limit = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         case ($urandom_range(0, 3))
            0, 1:    prio = $urandom_range(0, 6) - 3;
            2:       prio = $urandom();
            default: prio = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         endcase
         op = $urandom_range(0, 99);
         if (op < 55)      send_request(REQ_INSERT, pick_value(), prio);
         else if (op < 77) send_request(REQ_DELETE, pick_value(), $urandom());
         else if (op < 97) send_request(REQ_READOUT, $urandom(), $urandom());
         else              send_request(REQ_CLEAR, $urandom(), $urandom());
      end
      req_tvalid <= 1'b0;

      // Let the checker see the last request, then wait for its results.
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d inserts, %0d deletes, %0d clears and %0d read outs;",
               sent_by_kind[REQ_INSERT], sent_by_kind[REQ_DELETE],
               sent_by_kind[REQ_CLEAR], sent_by_kind[REQ_READOUT]);
      $display("compared %0d result items, %0d mismatches.", checked_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
